/* design/fxalu_pkg.sv */
// shared types, opcodes and helpers for the fixed-point alu
package fxalu_pkg;

  // fraction bits of the fixed-point format
  localparam int unsigned FracBits = 8;
  // dividend magnitude width: 32 bits shifted left by FracBits
  localparam int unsigned NumW = 32 + FracBits;
  // one quotient bit is settled in each divider cell
  localparam int unsigned NumCells = NumW;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_CMP      = 4'd6,
    OP_INC      = 4'd7,
    OP_DEC      = 4'd8,
    OP_TO_INT   = 4'd9,
    OP_FROM_INT = 4'd10
  } opcode_e;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               overflowed;
    logic               divided_by_zero;
  } rsp_t;

  // item travelling down the cell row
  typedef struct packed {
    logic            valid;
    rsp_t            rsp;      // final answer unless a nonzero divide
    logic            is_div;
    logic            neg;      // quotient sign
    logic [NumW-1:0] num;      // dividend bits still to shift in
    logic [NumW:0]   rem;      // partial remainder
    logic [NumW-1:0] quo;      // quotient bits so far
    logic [32:0]     den;      // divisor magnitude
  } cell_t;

  // saturate a 34-bit signed sum to 32 bits
  function automatic logic [32:0] sat34(input logic signed [33:0] v);
    logic [32:0] r;
    if (v > 34'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -34'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

/* design/fxalu_front.sv */
// input stage: finishes every op but a nonzero divide, which it prepares
module fxalu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fxalu_pkg::req_t   req_i,
  output fxalu_pkg::cell_t  cell_o
);

  logic signed [31:0] a, b;
  logic signed [63:0] prod_q;
  logic [3:0]         op_q;
  fxalu_pkg::req_t    req_q;
  logic               valid_q;
  fxalu_pkg::cell_t   cell_d, cell_q;
  logic [63:0]        pmag;
  logic [63:0]        prnd;
  logic signed [65:0] pres;
  logic [32:0]        s;
  logic [31:0]        amag, bmag;

  assign a = req_i.operand_a;
  assign b = req_i.operand_b;

  // multiplier stage, registered before rounding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a * b;
      req_q  <= req_i;
    end
  end

  assign op_q = req_q.opcode;
  assign amag = req_q.operand_a[31] ? 32'(-req_q.operand_a) : req_q.operand_a;
  assign bmag = req_q.operand_b[31] ? 32'(-req_q.operand_b) : req_q.operand_b;
  assign pmag = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
  assign prnd = (pmag + (64'd1 << (fxalu_pkg::FracBits - 1))) >> fxalu_pkg::FracBits;
  assign pres = prod_q[63] ? -$signed({2'b00, prnd}) : $signed({2'b00, prnd});

  // finish the simple operations
  always_comb begin
    logic signed [31:0] ra, rb;
    logic signed [65:0] fi;
    ra = req_q.operand_a;
    rb = req_q.operand_b;
    fi = 66'(ra) <<< fxalu_pkg::FracBits;
    s  = '0;
    cell_d = '0;
    cell_d.valid = valid_q;
    cell_d.rsp.is_less    = ra < rb;
    cell_d.rsp.is_equal   = ra == rb;
    cell_d.rsp.is_greater = ra > rb;
    case (op_q)
      fxalu_pkg::OP_ADD: s = fxalu_pkg::sat34(34'(ra) + 34'(rb));
      fxalu_pkg::OP_SUB: s = fxalu_pkg::sat34(34'(ra) - 34'(rb));
      fxalu_pkg::OP_MUL: begin
        if (pres > 66'sd2147483647) s = {1'b1, 32'h7fffffff};
        else if (pres < -66'sd2147483648) s = {1'b1, 32'h80000000};
        else s = {1'b0, pres[31:0]};
      end
      fxalu_pkg::OP_MIN: s = {1'b0, (ra < rb) ? ra : rb};
      fxalu_pkg::OP_MAX: s = {1'b0, (ra > rb) ? ra : rb};
      fxalu_pkg::OP_INC: s = fxalu_pkg::sat34(34'(ra) + 34'sd1);
      fxalu_pkg::OP_DEC: s = fxalu_pkg::sat34(34'(ra) - 34'sd1);
      fxalu_pkg::OP_TO_INT: s = {1'b0, 32'(ra >>> fxalu_pkg::FracBits)};
      fxalu_pkg::OP_FROM_INT: begin
        if (fi > 66'sd2147483647) s = {1'b1, 32'h7fffffff};
        else if (fi < -66'sd2147483648) s = {1'b1, 32'h80000000};
        else s = {1'b0, fi[31:0]};
      end
      fxalu_pkg::OP_DIV: begin
        if (rb == 32'sd0) begin
          cell_d.rsp.divided_by_zero = 1'b1;
          if (ra > 0) s = {1'b0, 32'h7fffffff};
          else if (ra < 0) s = {1'b0, 32'h80000000};
        end else begin
          cell_d.is_div = 1'b1;
        end
      end
      default: s = '0;
    endcase
    cell_d.rsp.result     = s[31:0];
    cell_d.rsp.overflowed = s[32];
    cell_d.neg = ra[31] ^ rb[31];
    cell_d.num = {amag, {fxalu_pkg::FracBits{1'b0}}};
    cell_d.den = {1'b0, bmag};
  end

  // prepare stage register feeding the divider row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* design/fxalu_cell.sv */
// one restoring-division cell: settles one quotient bit and hands on
module fxalu_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fxalu_pkg::cell_t  cell_i,
  output fxalu_pkg::cell_t  cell_o
);

  fxalu_pkg::cell_t cell_d, cell_q;
  logic [fxalu_pkg::NumW:0] sh;
  logic [fxalu_pkg::NumW:0] dif;

  // shift in the next dividend bit and try the subtract
  assign sh  = {cell_i.rem[fxalu_pkg::NumW-1:0], cell_i.num[fxalu_pkg::NumW-1]};
  assign dif = sh - (fxalu_pkg::NumW+1)'(cell_i.den);

  always_comb begin
    cell_d = cell_i;
    cell_d.num = cell_i.num << 1;
    if (!dif[fxalu_pkg::NumW]) begin
      cell_d.rem = dif;
      cell_d.quo = {cell_i.quo[fxalu_pkg::NumW-2:0], 1'b1};
    end else begin
      cell_d.rem = sh;
      cell_d.quo = {cell_i.quo[fxalu_pkg::NumW-2:0], 1'b0};
    end
  end

  // cell register handing on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* design/fxalu_back.sv */
// output stage: rounds the quotient, saturates and holds the response
module fxalu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fxalu_pkg::cell_t  cell_i,
  output logic              valid_o,
  output fxalu_pkg::rsp_t   rsp_o
);

  fxalu_pkg::rsp_t          rsp_d, rsp_q;
  logic                     valid_q;
  logic [fxalu_pkg::NumW:0] q;
  logic [fxalu_pkg::NumW+1:0] r2;
  logic                     up;

  // round half away from zero: bump when twice the remainder reaches the divisor
  assign r2 = {cell_i.rem, 1'b0};
  assign up = r2 >= (fxalu_pkg::NumW+2)'(cell_i.den);
  assign q  = {1'b0, cell_i.quo} + (fxalu_pkg::NumW+1)'(up);

  always_comb begin
    rsp_d = cell_i.rsp;
    if (cell_i.is_div) begin
      if (!cell_i.neg) begin
        if (q > (fxalu_pkg::NumW+1)'(32'h7fffffff)) begin
          rsp_d.result = 32'h7fffffff;
          rsp_d.overflowed = 1'b1;
        end else begin
          rsp_d.result = q[31:0];
        end
      end else begin
        if (q > (fxalu_pkg::NumW+1)'(33'h080000000)) begin
          rsp_d.result = 32'h80000000;
          rsp_d.overflowed = 1'b1;
        end else begin
          rsp_d.result = 32'(-q[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

/* design/fixed_point_alu.sv */
// fixed-point alu top level: front stage, divider cell row and output stage
// Signed 32-bit fixed-point ALU (8 fraction bits) that takes one request per
// cycle and returns one response per request, in order, after it passes
// one multiply stage, one prepare stage, a row of 40 division cells that
// settle one quotient bit each, and an output register. Every operation
// travels the full row so ordering is kept. The whole row advances together
// and halts while the output is held by out_stall_i; in_stall_o then follows
// it, so the block takes one request per cycle whenever the downstream side
// takes responses.
module fixed_point_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fxalu_pkg::req_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fxalu_pkg::rsp_t  out_data_o
);

  fxalu_pkg::cell_t chain [fxalu_pkg::NumCells+1];
  logic             en;

  // the row moves whenever the output is free or taken
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  fxalu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_data_i),
    .cell_o  (chain[0])
  );

  for (genvar i = 0; i < fxalu_pkg::NumCells; i++) begin : g_cell
    fxalu_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  fxalu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cell_i  (chain[fxalu_pkg::NumCells]),
    .valid_o (out_valid_o),
    .rsp_o   (out_data_o)
  );

  // a held response keeps the input side stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input accepted while output held");

  // a held response does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_valid_o && out_stall_i) |-> $stable(out_data_o))
    else $error("held response changed");

  // only one comparison flag at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({out_data_o.is_less, out_data_o.is_equal,
                             out_data_o.is_greater}))
    else $error("comparison flags not one-hot");

  // divide by zero never reports overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.divided_by_zero) |-> !out_data_o.overflowed)
    else $error("overflow with divide by zero");

endmodule

/* tb/fixed_point_alu_tb.sv */
// self-checking testbench for the fixed-point alu: random and directed requests, scoreboard
`timescale 1ns / 100ps

module fixed_point_alu_tb;

  localparam int unsigned LatencyCycles = 43;
  localparam longint CycleLimit = 400000;
  localparam longint Max32 = 64'sd2147483647;
  localparam longint Min32 = -64'sd2147483648;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  fxalu_pkg::req_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  fxalu_pkg::rsp_t out_data_o;

  fxalu_pkg::req_t pending_reqs[$];
  fxalu_pkg::rsp_t expected_rsps[$];
  int     error_count = 0;
  longint cycle_count = 0;
  bit     calm_phase;
  bit     drain_hold;

  fixed_point_alu dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // saturate to 32 bits and flag the clip
  function automatic longint clip32(input longint v, inout logic ov);
    if (v > Max32) begin
      ov = 1'b1;
      return Max32;
    end
    if (v < Min32) begin
      ov = 1'b1;
      return Min32;
    end
    return v;
  endfunction

  // expected alu response for one request
  function automatic fxalu_pkg::rsp_t alu_predict(input fxalu_pkg::req_t req);
    fxalu_pkg::rsp_t rsp;
    longint a, b, p, q, n, d, r;
    logic   ov;
    a = longint'(req.operand_a);
    b = longint'(req.operand_b);
    r = 0;
    ov = 1'b0;
    rsp = '0;
    case (req.opcode)
      fxalu_pkg::OP_ADD: r = clip32(a + b, ov);
      fxalu_pkg::OP_SUB: r = clip32(a - b, ov);
      fxalu_pkg::OP_MUL: begin
        p = a * b;
        q = ((p < 0 ? -p : p) + (64'sd1 <<< (fxalu_pkg::FracBits - 1)))
            >>> fxalu_pkg::FracBits;
        r = clip32(p < 0 ? -q : q, ov);
      end
      fxalu_pkg::OP_DIV: begin
        if (b == 0) begin
          rsp.divided_by_zero = 1'b1;
          r = (a > 0) ? Max32 : ((a < 0) ? Min32 : 0);
        end else begin
          n = (a < 0 ? -a : a) <<< fxalu_pkg::FracBits;
          d = b < 0 ? -b : b;
          q = (2 * n + d) / (2 * d);
          r = clip32(((a < 0) != (b < 0)) ? -q : q, ov);
        end
      end
      fxalu_pkg::OP_MIN: r = (a < b) ? a : b;
      fxalu_pkg::OP_MAX: r = (a > b) ? a : b;
      fxalu_pkg::OP_CMP: r = 0;
      fxalu_pkg::OP_INC: r = clip32(a + 1, ov);
      fxalu_pkg::OP_DEC: r = clip32(a - 1, ov);
      fxalu_pkg::OP_TO_INT: r = a >>> fxalu_pkg::FracBits;
      fxalu_pkg::OP_FROM_INT: r = clip32(a * (64'sd1 <<< fxalu_pkg::FracBits), ov);
      default: r = 0;
    endcase
    rsp.result = r[31:0];
    rsp.is_less = a < b;
    rsp.is_equal = a == b;
    rsp.is_greater = a > b;
    rsp.overflowed = ov;
    return rsp;
  endfunction

  // random operand biased toward edges and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 8) - 4;
      3, 4: return 32'($signed($urandom_range(0, 8191)) - 4096);
      5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    fxalu_pkg::req_t req;
    req.opcode = op;
    req.operand_a = a;
    req.operand_b = b;
    pending_reqs.push_back(req);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && !drain_hold
          && (calm_phase || $urandom_range(0, 99) >= 26)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_reqs[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // track accepted requests for prediction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) expected_rsps.push_back(alu_predict(in_data_i));
  end

  // response monitor and downstream stall
  always @(posedge clk_i or negedge rst_ni) begin
    fxalu_pkg::rsp_t exp_rsp;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm_phase && ($urandom_range(0, 99) < 26);
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", out_data_o);
          error_count++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_data_o.result !== exp_rsp.result) begin
            $error("result: expected %0d actual %0d", exp_rsp.result, out_data_o.result);
            error_count++;
          end
          if (out_data_o.is_less !== exp_rsp.is_less) begin
            $error("is_less: expected %0b actual %0b", exp_rsp.is_less, out_data_o.is_less);
            error_count++;
          end
          if (out_data_o.is_equal !== exp_rsp.is_equal) begin
            $error("is_equal: expected %0b actual %0b", exp_rsp.is_equal, out_data_o.is_equal);
            error_count++;
          end
          if (out_data_o.is_greater !== exp_rsp.is_greater) begin
            $error("is_greater: expected %0b actual %0b", exp_rsp.is_greater,
                   out_data_o.is_greater);
            error_count++;
          end
          if (out_data_o.overflowed !== exp_rsp.overflowed) begin
            $error("overflowed: expected %0b actual %0b", exp_rsp.overflowed,
                   out_data_o.overflowed);
            error_count++;
          end
          if (out_data_o.divided_by_zero !== exp_rsp.divided_by_zero) begin
            $error("divided_by_zero: expected %0b actual %0b", exp_rsp.divided_by_zero,
                   out_data_o.divided_by_zero);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** fixed_point_alu: FAILED **");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [3:0] op;
    calm_phase = 1'b0;
    drain_hold = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every opcode, edges, divide by zero, unused codes
    push_req(fxalu_pkg::OP_ADD, 32'h7fffffff, 32'h00000001);
    push_req(fxalu_pkg::OP_SUB, 32'h80000000, 32'h00000001);
    push_req(fxalu_pkg::OP_MUL, 32'h7fffffff, 32'h7fffffff);
    push_req(fxalu_pkg::OP_MUL, 32'h80000000, 32'h80000000);
    push_req(fxalu_pkg::OP_MUL, 32'h00000180, 32'hffffff80);
    push_req(fxalu_pkg::OP_DIV, 32'h00000100, 32'h00000000);
    push_req(fxalu_pkg::OP_DIV, 32'hffffff00, 32'h00000000);
    push_req(fxalu_pkg::OP_DIV, 32'h00000000, 32'h00000000);
    push_req(fxalu_pkg::OP_DIV, 32'h80000000, 32'h00000001);
    push_req(fxalu_pkg::OP_DIV, 32'h00000100, 32'h00000300);
    push_req(fxalu_pkg::OP_MIN, 32'h80000000, 32'h7fffffff);
    push_req(fxalu_pkg::OP_MAX, 32'h00000005, 32'h00000005);
    push_req(fxalu_pkg::OP_CMP, 32'h12345678, 32'h12345678);
    push_req(fxalu_pkg::OP_INC, 32'h7fffffff, 32'h00000000);
    push_req(fxalu_pkg::OP_DEC, 32'h80000000, 32'h00000000);
    push_req(fxalu_pkg::OP_TO_INT, 32'hffffff01, 32'h00000000);
    push_req(fxalu_pkg::OP_TO_INT, 32'h7fffffff, 32'hffffffff);
    push_req(fxalu_pkg::OP_FROM_INT, 32'h00800000, 32'h00000000);
    push_req(fxalu_pkg::OP_FROM_INT, 32'hff7fffff, 32'h00000000);
    push_req(4'd11, 32'h00000001, 32'h00000002);
    push_req(4'd15, 32'hffffffff, 32'h00000000);
    while (pending_reqs.size() > 0) @(posedge clk_i);

    // sender holds off until everything has drained
    drain_hold = 1'b1;
    while (expected_rsps.size() > 0 || in_valid_i) @(posedge clk_i);
    drain_hold = 1'b0;

    // random requests, with a calm stretch in the middle
    for (int i = 0; i < 1850; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                         : 4'($urandom_range(0, 10));
      push_req(op, pick_operand(), pick_operand());
      if (i == 700) begin
        while (pending_reqs.size() > 0) @(posedge clk_i);
        calm_phase = 1'b1;
      end
      if (i == 1000) begin
        while (pending_reqs.size() > 0) @(posedge clk_i);
        calm_phase = 1'b0;
      end
    end
    while (pending_reqs.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_rsps.size() > 0) @(posedge clk_i);
    repeat (LatencyCycles + 5) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** fixed_point_alu: PASSED **");
    end else begin
      $display("** fixed_point_alu: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/fxalu_pkg.sv
design/fxalu_front.sv
design/fxalu_cell.sv
design/fxalu_back.sv
design/fixed_point_alu.sv
tb/fixed_point_alu_tb.sv
